### src/erv_pkg.sv
// ----------------------------------------------------------------------------
// erv_pkg
// Shared constants, types and arithmetic helpers for the vertex rotation block.
// ----------------------------------------------------------------------------
package erv_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int ANGLE_BITS     = 16;
    localparam int QTR_BITS       = ANGLE_BITS - 2;
    // Accumulator of three coefficient by coordinate products
    localparam int ACC_W          = COEF_W + COORD_WIDTH + 2;
    // Rounded accumulator, before saturation
    localparam int RND_W          = ACC_W - COEF_FRAC_BITS;
    localparam int IDX_W          = 3;

    // pi/2 in Q30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC_BITS;

    typedef enum logic [IDX_W-1:0] {
        REG_ANGLE_X  = 3'd0,
        REG_ANGLE_Y  = 3'd1,
        REG_ANGLE_Z  = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4
    } cfg_index_t;

    typedef logic signed [COEF_W-1:0] coef_val_t;

    // Rotation matrix, row major
    typedef struct packed {
        coef_val_t c00; coef_val_t c01; coef_val_t c02;
        coef_val_t c10; coef_val_t c11; coef_val_t c12;
        coef_val_t c20; coef_val_t c21; coef_val_t c22;
    } coef_t;

    // Request to and response from the sine unit
    typedef struct packed {
        logic                  start;
        logic [ANGLE_BITS-1:0] angle;
    } trig_req_t;

    typedef struct packed {
        logic      done;
        coef_val_t value;
    } trig_rsp_t;

    // Shift right by the fraction width, rounding to nearest, ties away from zero.
    function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] biased;
        biased = a + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1)) - ACC_W'(a[ACC_W-1]);
        return biased[ACC_W-1:COEF_FRAC_BITS];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [RND_W-1:0] a);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = RND_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
        lo = -hi - RND_W'(1);
        if (a > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if (a < lo) begin
            return lo[COORD_WIDTH-1:0];
        end
        return a[COORD_WIDTH-1:0];
    endfunction

    function automatic coef_val_t sat_coef(input logic signed [RND_W-1:0] a);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = RND_W'((64'sd1 <<< (COEF_W - 1)) - 64'sd1);
        lo = -hi - RND_W'(1);
        if (a > hi) begin
            return hi[COEF_W-1:0];
        end else if (a < lo) begin
            return lo[COEF_W-1:0];
        end
        return a[COEF_W-1:0];
    endfunction

endpackage

### src/erv_trig.sv
// ----------------------------------------------------------------------------
// erv_trig
// Iterative sine unit: Taylor series to the eleventh power on one quarter wave
// in Q30, with one shared multiplier. Each series term is divided by its
// constant denominator through a two-part reciprocal multiplication.
// ----------------------------------------------------------------------------
module erv_trig import erv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  trig_req_t req,
    output trig_rsp_t rsp
);

    typedef enum logic [2:0] {
        T_IDLE, T_X, T_X2, T_MUL, T_DLO, T_DHI, T_FIN
    } tstate_t;

    localparam int RSHIFT      = 30 - COEF_FRAC_BITS;
    localparam int MAG_W       = 32 - RSHIFT + 1;
    // Reciprocals are ceil(2^RECIP_SHIFT / d), exact for 32-bit numerators.
    localparam int RECIP_SHIFT = 39;
    localparam int RECIP_HI_W  = 5;
    localparam int QSUM_W      = 38;

    tstate_t           state_reg, state_next;
    logic [QTR_BITS:0] r_reg, r_next;
    logic              neg_reg, neg_next;
    logic [30:0]       x_reg, x_next;
    logic [31:0]       x2_reg, x2_next;
    logic [30:0]       term_reg, term_next;
    logic [31:0]       sum_reg, sum_next;
    logic [2:0]        k_reg, k_next;
    logic [31:0]       num_reg, num_next;
    logic [31:0]       lo_reg, lo_next;
    logic              done_reg, done_next;
    coef_val_t         val_reg, val_next;

    logic [31:0]           mul_a, mul_b;
    logic [63:0]           prod;
    logic [31:0]           recip_lo;
    logic [RECIP_HI_W-1:0] recip_hi;
    logic [QSUM_W-1:0]     qsum;
    logic [30:0]           quot;
    logic [32:0]           rsum;
    logic [MAG_W-1:0]      mag;
    logic [QTR_BITS-1:0]   r_in;

    // Reciprocal of the denominator (2k)(2k+1) of the current series term
    always_comb begin
        unique case (k_reg)
            3'd1:    begin recip_hi = 5'd21; recip_lo = 32'h5555_5556; end
            3'd2:    begin recip_hi = 5'd6;  recip_lo = 32'h6666_6667; end
            3'd3:    begin recip_hi = 5'd3;  recip_lo = 32'h0C30_C30D; end
            3'd4:    begin recip_hi = 5'd1;  recip_lo = 32'hC71C_71C8; end
            3'd5:    begin recip_hi = 5'd1;  recip_lo = 32'h29E4_129F; end
            default: begin recip_hi = 5'd21; recip_lo = 32'h5555_5556; end
        endcase
    end

    // Shared multiplier, its operands chosen by the state.
    always_comb begin
        unique case (state_reg)
            T_X: begin
                mul_a = 32'(r_reg);
                mul_b = 32'(HALF_PI_Q30);
            end
            T_X2: begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            T_DLO: begin
                mul_a = num_reg;
                mul_b = recip_lo;
            end
            T_DHI: begin
                mul_a = num_reg;
                mul_b = 32'(recip_hi);
            end
            default: begin
                mul_a = 32'(term_reg);
                mul_b = x2_reg;
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    // Quotient from the two reciprocal partial products, and the final rounding.
    always_comb begin
        qsum   = QSUM_W'(prod[36:0]) + QSUM_W'(lo_reg);
        quot   = qsum[QSUM_W-1:RECIP_SHIFT-32];
        rsum   = 33'(sum_reg) + (33'(1) << (RSHIFT - 1));
        mag    = rsum[32:RSHIFT];
        if (mag > MAG_W'(COEF_ONE)) begin
            mag = MAG_W'(COEF_ONE);
        end
        r_in   = req.angle[QTR_BITS-1:0];
    end

    // Sequencer and registers.
    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        num_next   = num_reg;
        lo_next    = lo_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        if (req.start) begin
            // Fold the angle onto the first quadrant
            if (req.angle[QTR_BITS]) begin
                r_next = (QTR_BITS+1)'(1 << QTR_BITS) - (QTR_BITS+1)'(r_in);
            end else begin
                r_next = (QTR_BITS+1)'(r_in);
            end
            neg_next   = req.angle[QTR_BITS+1];
            state_next = T_X;
        end else begin
            unique case (state_reg)
                T_IDLE: begin
                end
                T_X: begin
                    x_next     = prod[QTR_BITS+30:QTR_BITS];
                    state_next = T_X2;
                end
                T_X2: begin
                    x2_next    = prod[61:30];
                    term_next  = x_reg;
                    sum_next   = 32'(x_reg);
                    k_next     = 3'd1;
                    state_next = T_MUL;
                end
                T_MUL: begin
                    num_next   = prod[61:30];
                    state_next = T_DLO;
                end
                T_DLO: begin
                    lo_next    = prod[63:32];
                    state_next = T_DHI;
                end
                T_DHI: begin
                    term_next = quot;
                    if (k_reg[0]) begin
                        sum_next = sum_reg - 32'(quot);
                    end else begin
                        sum_next = sum_reg + 32'(quot);
                    end
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'd5) begin
                        state_next = T_FIN;
                    end else begin
                        state_next = T_MUL;
                    end
                end
                T_FIN: begin
                    val_next   = neg_reg ? -COEF_W'(mag) : COEF_W'(mag);
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
                default: begin
                    state_next = T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        r_reg    <= r_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        k_reg    <= k_next;
        num_reg  <= num_next;
        lo_reg   <= lo_next;
        val_reg  <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

### src/erv_coef.sv
// ----------------------------------------------------------------------------
// erv_coef
// Builds the rotation matrix Rx*Ry*Rz from the three angles: six sine
// evaluations, then ten rounded products or product pairs on one multiplier.
// ----------------------------------------------------------------------------
module erv_coef import erv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rebuild,
    input  logic [ANGLE_BITS-1:0] angle_x,
    input  logic [ANGLE_BITS-1:0] angle_y,
    input  logic [ANGLE_BITS-1:0] angle_z,
    output coef_t                 coef,
    output logic                  busy
);

    typedef enum logic [1:0] {C_TRIG, C_WAIT, C_MAT, C_IDLE} cstate_t;

    cstate_t   state_reg;
    logic [2:0] e_reg;
    logic [3:0] t_reg;
    logic [1:0] ph_reg;
    coef_val_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    coef_val_t m10_reg, m20_reg;
    coef_t     coef_reg;
    logic signed [ACC_W-1:0] acc_reg;

    trig_req_t req;
    trig_rsp_t rsp;
    logic [ANGLE_BITS-1:0] ang_sel;
    coef_val_t a0, b0, a1, b1, op_a, op_b;
    logic signed [ACC_W-1:0] prod;
    coef_val_t result;

    erv_trig u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Angle for the current evaluation; cosine is sine a quarter turn on.
    always_comb begin
        unique case (e_reg[2:1])
            2'd0:    ang_sel = angle_x;
            2'd1:    ang_sel = angle_y;
            default: ang_sel = angle_z;
        endcase
        req.start = (state_reg == C_TRIG) && !rebuild;
        req.angle = e_reg[0] ? ang_sel + (ANGLE_BITS'(1) << QTR_BITS) : ang_sel;
    end

    // Operand schedule of the matrix products.
    always_comb begin
        a1 = '0;
        b1 = '0;
        unique case (t_reg)
            4'd0: begin a0 = sx_reg;  b0 = sy_reg; end
            4'd1: begin a0 = sx_reg;  b0 = cy_reg; end
            4'd2: begin a0 = cx_reg;  b0 = sy_reg; end
            4'd3: begin a0 = cx_reg;  b0 = cy_reg; end
            4'd4: begin a0 = cy_reg;  b0 = cz_reg; end
            4'd5: begin a0 = cy_reg;  b0 = sz_reg; end
            4'd6: begin a0 = m10_reg; b0 = cz_reg; a1 = cx_reg;  b1 = -sz_reg; end
            4'd7: begin a0 = m10_reg; b0 = sz_reg; a1 = cx_reg;  b1 = cz_reg;  end
            4'd8: begin a0 = m20_reg; b0 = cz_reg; a1 = sx_reg;  b1 = sz_reg;  end
            default: begin a0 = m20_reg; b0 = sz_reg; a1 = -sx_reg; b1 = cz_reg; end
        endcase
        op_a   = (ph_reg == 2'd0) ? a0 : a1;
        op_b   = (ph_reg == 2'd0) ? b0 : b1;
        prod   = ACC_W'(op_a) * ACC_W'(op_b);
        result = sat_coef(rnd_frac(acc_reg));
    end

    // Rebuild sequencer: state and coefficient registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_TRIG;
            e_reg     <= '0;
            t_reg     <= '0;
            ph_reg    <= '0;
        end else if (rebuild) begin
            state_reg <= C_TRIG;
            e_reg     <= '0;
        end else begin
            unique case (state_reg)
                C_TRIG: begin
                    state_reg <= C_WAIT;
                end
                C_WAIT: begin
                    if (rsp.done) begin
                        unique case (e_reg)
                            3'd0:    sx_reg <= rsp.value;
                            3'd1:    cx_reg <= rsp.value;
                            3'd2:    sy_reg <= rsp.value;
                            3'd3:    cy_reg <= rsp.value;
                            3'd4:    sz_reg <= rsp.value;
                            default: cz_reg <= rsp.value;
                        endcase
                        if (e_reg == 3'd5) begin
                            state_reg <= C_MAT;
                            t_reg     <= '0;
                            ph_reg    <= '0;
                        end else begin
                            e_reg     <= e_reg + 3'd1;
                            state_reg <= C_TRIG;
                        end
                    end
                end
                C_MAT: begin
                    unique case (ph_reg)
                        2'd0: begin
                            acc_reg <= prod;
                            ph_reg  <= 2'd1;
                        end
                        2'd1: begin
                            acc_reg <= acc_reg + prod;
                            ph_reg  <= 2'd2;
                        end
                        default: begin
                            unique case (t_reg)
                                4'd0: begin
                                    m10_reg      <= result;
                                    coef_reg.c02 <= -sy_reg;
                                end
                                4'd1:    coef_reg.c12 <= result;
                                4'd2:    m20_reg      <= result;
                                4'd3:    coef_reg.c22 <= result;
                                4'd4:    coef_reg.c00 <= result;
                                4'd5:    coef_reg.c01 <= result;
                                4'd6:    coef_reg.c10 <= result;
                                4'd7:    coef_reg.c11 <= result;
                                4'd8:    coef_reg.c20 <= result;
                                default: coef_reg.c21 <= result;
                            endcase
                            ph_reg <= 2'd0;
                            t_reg  <= t_reg + 4'd1;
                            if (t_reg == 4'd9) begin
                                state_reg <= C_IDLE;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign coef = coef_reg;
    assign busy = state_reg != C_IDLE;

    // The matrix only changes while a rebuild runs.
    a_coef_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy && !rebuild) |=> $stable(coef))
        else $error("coefficients changed outside a rebuild");

    // An angle write always starts a rebuild.
    a_rebuild_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rebuild |=> (busy && state_reg == C_TRIG && e_reg == 3'd0))
        else $error("angle write did not restart the rebuild");

    // The sine unit answers only while this sequencer waits for it, or when a rebuild has cut short the wait.
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == C_WAIT || $past(rebuild)))
        else $error("unexpected sine result");

endmodule

### src/erv_datapath.sv
// ----------------------------------------------------------------------------
// erv_datapath
// Vertex pipe: input register, matrix-vector product with rounding and
// saturation, screen offsets, and the result register.
// ----------------------------------------------------------------------------
module erv_datapath import erv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          hold,
    input  coef_t                         coef,
    input  logic signed [COORD_WIDTH-1:0] offset_x,
    input  logic signed [COORD_WIDTH-1:0] offset_y,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_rotated_x,
    output logic signed [COORD_WIDTH-1:0] m_rotated_y,
    output logic signed [COORD_WIDTH-1:0] m_rotated_z,
    output logic signed [COORD_WIDTH-1:0] m_screen_x,
    output logic signed [COORD_WIDTH-1:0] m_screen_y
);

    logic in_valid_reg, out_valid_reg;
    logic signed [COORD_WIDTH-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, rz_reg, scx_reg, scy_reg;

    logic out_adv, s_fire;
    logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
    logic signed [COORD_WIDTH-1:0] rx_next, ry_next, rz_next;
    logic signed [COORD_WIDTH:0] sum_x, sum_y;

    // Handshake: the result register frees the input stage when it is empty or taken.
    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !hold && (!in_valid_reg || out_adv);
    assign s_fire  = s_valid && s_ready;

    // Matrix times vertex, then screen point.
    always_comb begin
        acc_x = ACC_W'(coef.c00) * ACC_W'(vx_reg) + ACC_W'(coef.c01) * ACC_W'(vy_reg)
              + ACC_W'(coef.c02) * ACC_W'(vz_reg);
        acc_y = ACC_W'(coef.c10) * ACC_W'(vx_reg) + ACC_W'(coef.c11) * ACC_W'(vy_reg)
              + ACC_W'(coef.c12) * ACC_W'(vz_reg);
        acc_z = ACC_W'(coef.c20) * ACC_W'(vx_reg) + ACC_W'(coef.c21) * ACC_W'(vy_reg)
              + ACC_W'(coef.c22) * ACC_W'(vz_reg);
        rx_next = sat_coord(rnd_frac(acc_x));
        ry_next = sat_coord(rnd_frac(acc_y));
        rz_next = sat_coord(rnd_frac(acc_z));
        sum_x   = (COORD_WIDTH+1)'(rz_next) + (COORD_WIDTH+1)'(offset_x);
        sum_y   = (COORD_WIDTH+1)'(ry_next) + (COORD_WIDTH+1)'(offset_y);
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (out_adv) begin
                in_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            vx_reg <= s_vertex_x;
            vy_reg <= s_vertex_y;
            vz_reg <= s_vertex_z;
        end
        if (out_adv && in_valid_reg) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rz_reg  <= rz_next;
            scx_reg <= sat_coord(RND_W'(sum_x));
            scy_reg <= sat_coord(RND_W'(sum_y));
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_rotated_x = rx_reg;
    assign m_rotated_y = ry_reg;
    assign m_rotated_z = rz_reg;
    assign m_screen_x  = scx_reg;
    assign m_screen_y  = scy_reg;

    // No transaction enters while the matrix is rebuilt.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        hold |-> !s_ready)
        else $error("vertex accepted during rebuild");

    // A stalled result keeps its stage occupied.
    a_out_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rotated_y) && $stable(m_screen_y)))
        else $error("result lost while stalled");

    // An accepted vertex always reaches the input stage.
    a_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> in_valid_reg)
        else $error("accepted vertex dropped");

endmodule

### src/euler_rotate_vertex_top.sv
// ----------------------------------------------------------------------------
// euler_rotate_vertex_top
// Rotates signed 3D vertices by R = Rx*Ry*Rz built from three configured
// angles, and adds screen offsets to rotated z and y.
// ----------------------------------------------------------------------------
// One vertex transaction is accepted per clock while no rebuild runs and the
// output is not stalled; its result passes the input register and then the
// result register, the only stages, so a stalled result never blocks
// acceptance of the next vertex beyond the one held in the input stage. After
// reset and after every angle write, s_ready stays low while the matrix is
// rebuilt: six sine evaluations (five series terms, each a product followed
// by a two-part reciprocal division) followed by ten matrix products. Offset
// writes take effect at once and need no rebuild.
module euler_rotate_vertex_top import erv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [ANGLE_BITS-1:0]         cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_rotated_x,
    output logic signed [COORD_WIDTH-1:0] m_rotated_y,
    output logic signed [COORD_WIDTH-1:0] m_rotated_z,
    output logic signed [COORD_WIDTH-1:0] m_screen_x,
    output logic signed [COORD_WIDTH-1:0] m_screen_y
);

    logic [ANGLE_BITS-1:0] angle_x_reg, angle_y_reg, angle_z_reg;
    logic signed [COORD_WIDTH-1:0] offset_x_reg, offset_y_reg;
    logic  rebuild;
    logic  busy;
    coef_t coef;

    // An angle write restarts the matrix rebuild.
    assign rebuild = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                             || cfg_index == REG_ANGLE_Z);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_x_reg  <= '0;
            angle_y_reg  <= '0;
            angle_z_reg  <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ANGLE_X:  angle_x_reg  <= cfg_wdata;
                REG_ANGLE_Y:  angle_y_reg  <= cfg_wdata;
                REG_ANGLE_Z:  angle_z_reg  <= cfg_wdata;
                REG_OFFSET_X: offset_x_reg <= COORD_WIDTH'(cfg_wdata);
                REG_OFFSET_Y: offset_y_reg <= COORD_WIDTH'(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    erv_coef u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rebuild (rebuild),
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .angle_z (angle_z_reg),
        .coef    (coef),
        .busy    (busy)
    );

    erv_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hold        (busy),
        .coef        (coef),
        .offset_x    (offset_x_reg),
        .offset_y    (offset_y_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_vertex_x  (s_vertex_x),
        .s_vertex_y  (s_vertex_y),
        .s_vertex_z  (s_vertex_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rotated_x (m_rotated_x),
        .m_rotated_y (m_rotated_y),
        .m_rotated_z (m_rotated_z),
        .m_screen_x  (m_screen_x),
        .m_screen_y  (m_screen_y)
    );

endmodule
